// File: hdl/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants of the line position estimator.
// ----------------------------------------------------------------------------
package lpe_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int STEP_W     = 6;
    localparam int POS_W      = 15;
    localparam int TOTAL_W    = 14;   // sum of three samples
    localparam int WEIGHT_W   = 20;   // sum of sample * weight
    localparam int NUMER_W    = WEIGHT_W + 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int LPE_QUEUE_DEPTH = 2;

    localparam logic [STEP_W-1:0]     STEP_MAX      = 6'd50;
    localparam logic [POS_W-1:0]      FULL_RIGHT_Q8 = 15'd25600;
    localparam logic [POS_W-1:0]      CENTRE_Q8     = 15'd12800;
    localparam logic [POS_W-1:0]      FULL_LEFT_Q8  = 15'd0;
    localparam logic [SAMPLE_W-1:0]   NOISE_RESET   = 12'd200;
    localparam logic [SAMPLE_W-1:0]   TRACK_RESET   = 12'd2000;
    localparam logic [STEP_W-1:0]     STEP_RESET    = 6'd50;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;

    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_LEFT  = 2'd1,
        EDGE_RIGHT = 2'd2
    } lpe_edge_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } lpe_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] noise_threshold;
        logic [SAMPLE_W-1:0] track_threshold;
        logic [STEP_W-1:0]   position_step;
    } lpe_cfg_t;

    // one classified frame waiting for the divider
    typedef struct packed {
        logic [NUMER_W-1:0] numer;
        logic [TOTAL_W-1:0] total;
        logic               frame_ok;
        lpe_edge_t          edge_upd;   // none means keep the stored edge
    } lpe_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lpe_qstat_t;

endpackage

// File: hdl/lpe_if.sv
// ----------------------------------------------------------------------------
// lpe_if
// Valid/ready channel interfaces of the line position estimator.
// ----------------------------------------------------------------------------
interface lpe_in_if
    import lpe_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_left;
    logic [SAMPLE_W-1:0] sample_centre;
    logic [SAMPLE_W-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_centre,
                    output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_centre,
                    input sample_right, output ready);
endinterface

interface lpe_out_if
    import lpe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position_q8;
    logic             line_seen;

    modport source (output valid, output position_q8, output line_seen, input ready);
    modport sink   (input valid, input position_q8, input line_seen, output ready);
endinterface

interface lpe_cfg_if
    import lpe_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/lpe_front.sv
// ----------------------------------------------------------------------------
// lpe_front
// Accepts sample frames, thresholds them and forms the centroid terms.
// ----------------------------------------------------------------------------
module lpe_front
    import lpe_pkg::*;
(
    lpe_in_if.sink      samples,
    input  lpe_cfg_t    cfg,
    input  lpe_qstat_t  qstat,
    output logic        push,
    output lpe_job_t    push_job
);

    logic [STEP_W-1:0]     step;
    logic                  hit_l, hit_c, hit_r;
    logic                  use_l, use_c, use_r;
    logic [SAMPLE_W-1:0]   v_l, v_c, v_r;
    logic [SAMPLE_W+STEP_W-1:0] prod_c, prod_r;
    logic [WEIGHT_W-1:0]   weighted;
    logic [TOTAL_W-1:0]    total;
    logic [1:0]            hits;

    assign samples.ready = !qstat.full;
    assign push          = samples.valid && !qstat.full;

    always_comb
    begin
        step  = (cfg.position_step > STEP_MAX) ? STEP_MAX : cfg.position_step;
        hit_l = samples.sample_left   > cfg.track_threshold;
        hit_c = samples.sample_centre > cfg.track_threshold;
        hit_r = samples.sample_right  > cfg.track_threshold;
        use_l = samples.sample_left   > cfg.noise_threshold;
        use_c = samples.sample_centre > cfg.noise_threshold;
        use_r = samples.sample_right  > cfg.noise_threshold;
        v_l   = use_l ? samples.sample_left   : '0;
        v_c   = use_c ? samples.sample_centre : '0;
        v_r   = use_r ? samples.sample_right  : '0;

        // weights 0, step and 2*step
        prod_c   = v_c * step;
        prod_r   = v_r * step;
        weighted = WEIGHT_W'(prod_c) + WEIGHT_W'({prod_r, 1'b0});
        total    = TOTAL_W'(v_l) + TOTAL_W'(v_c) + TOTAL_W'(v_r);
        hits     = 2'(hit_l) + 2'(hit_c) + 2'(hit_r);

        push_job.numer    = {weighted, 8'd0};
        push_job.total    = total;
        push_job.frame_ok = (hits != 2'd0) && (total != '0);
        if (hits == 2'd1 && hit_l)
        begin
            push_job.edge_upd = EDGE_LEFT;
        end
        else if (hits == 2'd1 && hit_r)
        begin
            push_job.edge_upd = EDGE_RIGHT;
        end
        else
        begin
            push_job.edge_upd = EDGE_NONE;
        end
    end

endmodule

// File: hdl/lpe_queue.sv
// ----------------------------------------------------------------------------
// lpe_queue
// Short job queue between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module lpe_queue
    import lpe_pkg::*;
#(
    parameter int DEPTH = LPE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lpe_job_t    push_job,
    input  logic        pop,
    output lpe_job_t    pop_job,
    output lpe_qstat_t  qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lpe_job_t          mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.empty = (count_reg == '0);
    assign pop_job     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/lpe_back.sv
// ----------------------------------------------------------------------------
// lpe_back
// Bit-serial divider, edge memory and result register.
// ----------------------------------------------------------------------------
module lpe_back
    import lpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lpe_qstat_t  qstat,
    input  lpe_job_t    pop_job,
    output logic        pop,
    lpe_out_if.source   result
);

    localparam int CNT_W = $clog2(NUMER_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUMER_W - 1);

    lpe_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [NUMER_W-1:0]  dq_reg, dq_next;
    logic [TOTAL_W-1:0]  denom_reg, denom_next;
    lpe_edge_t           upd_reg, upd_next;
    lpe_edge_t           edge_reg, edge_next;
    logic [POS_W-1:0]    held_reg, held_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                seen_reg, seen_next;
    logic [TOTAL_W:0]    trial;
    logic                qbit;
    logic [NUMER_W-1:0]  quot_full;
    logic [POS_W-1:0]    lost_pos;
    logic [POS_W-1:0]    quot_pos;

    assign result.valid       = (state_reg == ST_OUT);
    assign result.position_q8 = pos_reg;
    assign result.line_seen   = seen_reg;
    assign pop                = (state_reg == ST_IDLE) && !qstat.empty;

    always_comb
    begin
        // restoring division step: shift in one dividend bit
        trial     = {rem_reg, dq_reg[NUMER_W-1]};
        qbit      = (trial >= {1'b0, denom_reg});
        quot_full = {dq_reg[NUMER_W-2:0], qbit};

        unique case (edge_reg)
            EDGE_LEFT:  lost_pos = FULL_LEFT_Q8;
            EDGE_RIGHT: lost_pos = FULL_RIGHT_Q8;
            default:    lost_pos = held_reg;
        endcase

        if (quot_full[NUMER_W-1:POS_W] != '0 || quot_full[POS_W-1:0] > FULL_RIGHT_Q8)
        begin
            quot_pos = FULL_RIGHT_Q8;
        end
        else
        begin
            quot_pos = quot_full[POS_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        denom_next = denom_reg;
        upd_next   = upd_reg;
        edge_next  = edge_reg;
        held_next  = held_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (pop_job.frame_ok)
                    begin
                        cnt_next   = '0;
                        rem_next   = '0;
                        dq_next    = pop_job.numer;
                        denom_next = pop_job.total;
                        upd_next   = pop_job.edge_upd;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        pos_next   = lost_pos;
                        seen_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = qbit ? TOTAL_W'(trial - {1'b0, denom_reg}) : trial[TOTAL_W-1:0];
                dq_next  = quot_full;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    pos_next   = quot_pos;
                    held_next  = quot_pos;
                    seen_next  = 1'b1;
                    if (upd_reg != EDGE_NONE)
                    begin
                        edge_next = upd_reg;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        denom_reg <= denom_next;
        upd_reg   <= upd_next;
        pos_reg   <= pos_next;
        seen_reg  <= seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= EDGE_NONE;
            held_reg  <= CENTRE_Q8;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: hdl/line_position_estimator_top.sv
// ----------------------------------------------------------------------------
// line_position_estimator_top
// Weighted-centroid line position from three reflectance sensors.
//
//   channel   dir   payload                                   transaction
//   samples   in    sample_left, sample_centre, sample_right  valid && ready
//   result    out   position_q8, line_seen                    valid && ready
//   cfg       in    index, data                               valid && ready
//
// a frame that sees the line goes from the queue through the pop in ST_IDLE,
// 28 divider steps in ST_DIV and the handoff in ST_OUT; the bit-serial
// divider in the back end is the long part. a lost frame skips ST_DIV.
// the front keeps taking frames into the queue while a result waits, until it is full.
// reset clears the queue, the edge memory and loads the centre position.
// ----------------------------------------------------------------------------
module line_position_estimator_top
    import lpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = LPE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    lpe_cfg_if.sink     cfg,
    lpe_in_if.sink      samples,
    lpe_out_if.source   result
);

    lpe_cfg_t   cfg_reg;
    lpe_qstat_t qstat;
    lpe_job_t   push_job;
    lpe_job_t   pop_job;
    logic       push;
    logic       pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_threshold <= NOISE_RESET;
            cfg_reg.track_threshold <= TRACK_RESET;
            cfg_reg.position_step   <= STEP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NOISE: cfg_reg.noise_threshold <= cfg.data;
                REG_TRACK: cfg_reg.track_threshold <= cfg.data;
                REG_STEP:  cfg_reg.position_step   <= cfg.data[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    lpe_front u_front (
        .samples  (samples),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    lpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    lpe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .pop_job (pop_job),
        .pop     (pop),
        .result  (result)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.position_q8 <= FULL_RIGHT_Q8))
        else $error("position above full right");

    a_pop_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready) |=> !result.valid)
        else $error("result shown again after its transaction");

endmodule

// File: tb/sv/lpe_position_checker.sv
// ----------------------------------------------------------------------------
// lpe_position_checker
// Watches the configuration, sample and result channels of the line position
// estimator. It keeps its own copy of the thresholds, the step, the edge
// memory and the held position. From these it predicts the position and
// line_seen of every accepted frame. Each result transaction is compared
// with the oldest prediction, and the mismatch count is passed to the top.
// ----------------------------------------------------------------------------
module lpe_position_checker
    import lpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lpe_cfg_if          cfg,
    lpe_in_if           samples,
    lpe_out_if          result,
    output int unsigned errors,
    output int unsigned outstanding
);

    typedef struct {
        logic [POS_W-1:0] position_q8;
        logic             line_seen;
    } line_estimate_t;

    line_estimate_t      estimate_queue [$];
    line_estimate_t      oldest;

    logic [SAMPLE_W-1:0] noise_thr;
    logic [SAMPLE_W-1:0] track_thr;
    logic [STEP_W-1:0]   step_cfg;
    lpe_edge_t           edge_mem;
    logic [POS_W-1:0]    held_pos;

    // centroid of one frame; updates the edge memory and the held position
    function automatic line_estimate_t estimate_position(input logic [SAMPLE_W-1:0] left,
                                                         input logic [SAMPLE_W-1:0] centre,
                                                         input logic [SAMPLE_W-1:0] right);
        logic [SAMPLE_W-1:0] smp [3];
        logic [STEP_W-1:0]   weight_step;
        longint unsigned     weighted;
        longint unsigned     total;
        longint unsigned     quot;
        int                  hits;
        int                  last_hit;
        int                  k;
        line_estimate_t      est;

        smp[0]      = left;
        smp[1]      = centre;
        smp[2]      = right;
        weighted    = 0;
        total       = 0;
        hits        = 0;
        last_hit    = 0;
        weight_step = (step_cfg > STEP_MAX) ? STEP_MAX : step_cfg;

        for (k = 0; k < 3; k++)
        begin
            if (smp[k] > track_thr)
            begin
                hits++;
                last_hit = k;
            end
            if (smp[k] > noise_thr)
            begin
                weighted += longint'(smp[k]) * longint'(k) * longint'(weight_step);
                total    += longint'(smp[k]);
            end
        end

        // a sensor on the line with nothing above noise counts as lost
        if (hits > 0 && total > 0)
        begin
            quot = (weighted * 256) / total;
            if (quot > FULL_RIGHT_Q8)
                quot = FULL_RIGHT_Q8;
            if (hits == 1 && last_hit == 0)
                edge_mem = EDGE_LEFT;
            else if (hits == 1 && last_hit == 2)
                edge_mem = EDGE_RIGHT;
            held_pos        = quot[POS_W-1:0];
            est.position_q8 = held_pos;
            est.line_seen   = 1'b1;
        end
        else
        begin
            case (edge_mem)
                EDGE_LEFT:  est.position_q8 = FULL_LEFT_Q8;
                EDGE_RIGHT: est.position_q8 = FULL_RIGHT_Q8;
                default:    est.position_q8 = held_pos;
            endcase
            est.line_seen = 1'b0;
        end
        return est;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_thr   = NOISE_RESET;
            track_thr   = TRACK_RESET;
            step_cfg    = STEP_RESET;
            edge_mem    = EDGE_NONE;
            held_pos    = CENTRE_Q8;
            errors      = 0;
            outstanding = 0;
            estimate_queue.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_NOISE: noise_thr = cfg.data;
                    REG_TRACK: track_thr = cfg.data;
                    REG_STEP:  step_cfg  = cfg.data[STEP_W-1:0];
                    default:   ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (estimate_queue.size() == 0)
                begin
                    $error("result transaction with no frame pending: position_q8 %0d line_seen %0d",
                           result.position_q8, result.line_seen);
                    errors++;
                end
                else
                begin
                    oldest = estimate_queue.pop_front();
                    if (oldest.position_q8 !== result.position_q8)
                    begin
                        $error("position_q8 mismatch: expected %0d, actual %0d",
                               oldest.position_q8, result.position_q8);
                        errors++;
                    end
                    if (oldest.line_seen !== result.line_seen)
                    begin
                        $error("line_seen mismatch: expected %0d, actual %0d",
                               oldest.line_seen, result.line_seen);
                        errors++;
                    end
                end
            end

            if (samples.valid && samples.ready)
                estimate_queue.push_back(estimate_position(samples.sample_left,
                                                           samples.sample_centre,
                                                           samples.sample_right));

            outstanding = estimate_queue.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the line position estimator. A directed pass
// covers the sensor extremes, the threshold boundaries, edge memory, a zero
// and an oversized step, and track below noise. Random phases follow, each
// with new register settings and frames shaped around the thresholds. Both
// channels stall at random, not in the steady phase; checker does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import lpe_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PCT       = 23;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 90;
    localparam int STEADY_PHASE   = 5;
    localparam int STEADY_ITEMS   = 300;
    localparam int SAMPLE_MAX     = 4095;

    logic        clk;
    logic        rst_n;
    logic        steady;
    int unsigned error_count;
    int unsigned outstanding;
    int          noise_cur;
    int          track_cur;

    lpe_cfg_if cfg_if();
    lpe_in_if  samples_if();
    lpe_out_if result_if();

    line_position_estimator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .samples (samples_if),
        .result  (result_if)
    );

    lpe_position_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_if),
        .samples     (samples_if),
        .result      (result_if),
        .errors      (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    // result back-pressure
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic int clip12(input int v);
        return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] at_most(input int lim);
        return SAMPLE_W'($urandom_range(0, lim));
    endfunction

    function automatic logic [SAMPLE_W-1:0] above(input int lim);
        return (lim >= SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX)
                                   : SAMPLE_W'($urandom_range(lim + 1, SAMPLE_MAX));
    endfunction

    function automatic logic [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_W'(SAMPLE_MAX);
            2:       return SAMPLE_W'(clip12(track_cur + int'($urandom_range(2)) - 1));
            3:       return SAMPLE_W'(clip12(noise_cur + int'($urandom_range(2)) - 1));
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic send_frame(input logic [SAMPLE_W-1:0] left,
                              input logic [SAMPLE_W-1:0] centre,
                              input logic [SAMPLE_W-1:0] right);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid         <= 1'b1;
        samples_if.sample_left   <= left;
        samples_if.sample_centre <= centre;
        samples_if.sample_right  <= right;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random_frame();
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] centre;
        logic [SAMPLE_W-1:0] right;

        case ($urandom_range(9))
            0, 1:
            begin
                // line lost
                left   = at_most(track_cur);
                centre = at_most(track_cur);
                right  = at_most(track_cur);
            end
            2:
            begin
                left   = above(track_cur);
                centre = at_most(track_cur);
                right  = at_most(track_cur);
            end
            3:
            begin
                left   = at_most(track_cur);
                centre = at_most(track_cur);
                right  = above(track_cur);
            end
            default:
            begin
                left   = any_sample();
                centre = any_sample();
                right  = any_sample();
            end
        endcase
        send_frame(left, centre, right);
    endtask

    // stop sending and wait until every pending result has come back
    task automatic drain();
        samples_if.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_settings(input int noise, input int track,
                                  input logic [CFG_DATA_W-1:0] step_word);
        logic [CFG_IDX_W-1:0]  regs  [3];
        logic [CFG_DATA_W-1:0] words [3];
        int                    k;

        regs[0]  = REG_NOISE;
        regs[1]  = REG_TRACK;
        regs[2]  = REG_STEP;
        words[0] = CFG_DATA_W'(noise);
        words[1] = CFG_DATA_W'(track);
        words[2] = step_word;
        for (k = 0; k < 3; k++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[k];
            cfg_if.data  <= words[k];
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        noise_cur = noise;
        track_cur = track;
    endtask

    task automatic pick_settings(input int phase);
        int                    noise;
        int                    track;
        logic [CFG_DATA_W-1:0] step_word;

        if (phase == 0)
        begin
            noise     = NOISE_RESET;
            track     = TRACK_RESET;
            step_word = CFG_DATA_W'(STEP_RESET);
        end
        else
        begin
            case ($urandom_range(5))
                0:       noise = 0;
                1:       noise = SAMPLE_MAX;
                default: noise = $urandom_range(0, 1500);
            endcase
            case ($urandom_range(5))
                0:       track = 0;
                1:       track = SAMPLE_MAX;
                2:       track = $urandom_range(0, noise);
                default: track = $urandom_range(noise, SAMPLE_MAX);
            endcase
            // upper bits of the word are outside the step field
            step_word[CFG_DATA_W-1:STEP_W] = (CFG_DATA_W - STEP_W)'($urandom_range(63));
            step_word[STEP_W-1:0] = ($urandom_range(3) == 0) ? STEP_W'($urandom_range(63))
                                                             : STEP_W'($urandom_range(1, 50));
        end
        write_settings(noise, track, step_word);
    endtask

    initial
    begin
        int phase;
        int n;
        int items;

        rst_n                    <= 1'b0;
        steady                   <= 1'b0;
        samples_if.valid         <= 1'b0;
        samples_if.sample_left   <= '0;
        samples_if.sample_centre <= '0;
        samples_if.sample_right  <= '0;
        cfg_if.valid             <= 1'b0;
        cfg_if.index             <= REG_NOISE;
        cfg_if.data              <= '0;
        noise_cur = NOISE_RESET;
        track_cur = TRACK_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: edge memory and threshold boundaries
        send_frame(0, 0, 0);
        send_frame(4095, 4095, 4095);
        send_frame(4095, 0, 0);
        send_frame(0, 0, 0);
        send_frame(0, 0, 4095);
        send_frame(2000, 2000, 2000);
        send_frame(0, 4000, 0);
        send_frame(0, 0, 0);
        send_frame(2000, 2001, 200);
        send_frame(2001, 0, 2001);
        send_frame(201, 0, 4095);
        send_frame(4095, 201, 200);
        send_frame(1, 2, 4095);
        drain();

        // zero step puts every centroid at the left end
        write_settings(0, 0, 12'd0);
        send_frame(1, 1, 1);
        send_frame(0, 0, 1);
        send_frame(0, 0, 0);
        drain();

        // track below noise: on the line but no centroid weight; step saturates
        write_settings(SAMPLE_MAX, 0, 12'hFFF);
        send_frame(4095, 4095, 4095);
        send_frame(1, 0, 0);
        drain();

        // nothing can exceed the top threshold
        write_settings(0, SAMPLE_MAX, 12'h03F);
        send_frame(4095, 4095, 4095);
        drain();

        write_settings(0, 0, 12'd1);
        send_frame(4095, 0, 1);
        send_frame(0, 0, 4095);
        send_frame(1, 4095, 0);
        drain();

        write_settings(100, 3000, 12'd51);
        send_frame(4095, 101, 100);
        send_frame(4095, 4095, 4095);
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            pick_settings(phase);
            steady <= (phase == STEADY_PHASE);
            items = (phase == STEADY_PHASE) ? STEADY_ITEMS : PHASE_ITEMS;
            for (n = 0; n < items; n++)
                send_random_frame();
            drain();
        end
        steady <= 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lpe_pkg.sv
hdl/lpe_if.sv
hdl/lpe_front.sv
hdl/lpe_queue.sv
hdl/lpe_back.sv
hdl/line_position_estimator_top.sv
tb/sv/lpe_position_checker.sv
tb/sv/tb_top.sv
